// File: src/tswt_pkg.sv
package tswt_pkg;

	localparam int COORD_BITS_DEF = 9;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int OUT_W      = 24;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_LOCK_DISTANCE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PIXELS_PER_STEP = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BUTTON_BOUNDARY = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TAP_MAX_MS      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MULTITAP_MS     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_TAP_MAX_MOVE    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEPS       = 3'd6;

	// register reset values
	localparam logic [7:0]  LOCK_DISTANCE_RST   = 8'd12;
	localparam logic [7:0]  PIXELS_PER_STEP_RST = 8'd32;
	localparam logic [8:0]  BUTTON_BOUNDARY_RST = 9'd342;
	localparam logic [15:0] TAP_MAX_MS_RST      = 16'd280;
	localparam logic [15:0] MULTITAP_MS_RST     = 16'd600;
	localparam logic [7:0]  TAP_MAX_MOVE_RST    = 8'd14;
	localparam logic [6:0]  MAX_STEPS_RST       = 7'd8;

	localparam logic signed [7:0] PENDING_MAX     = 8'sd127;
	localparam logic signed [7:0] PENDING_MIN     = -8'sd127;
	localparam logic [1:0]        TAPS_TO_TOGGLE  = 2'd3;
	localparam logic [7:0]        MIN_STEP_PIXELS = 8'd8;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_DIV,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic capture;
		logic eval;
		logic div_step;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_done;
	} dp_sts_t;

endpackage

// File: src/touch_swipe_wheel_and_tap_toggle_unit.sv
// Touch swipe to wheel converter with a triple-tap controls toggle. Each input
// transaction is a touch sample (tuser = 0) or a consume of pending wheel steps
// (tuser = 1) and yields exactly one output transaction. An item is accepted,
// evaluated and handed to the output register. A sample that locks or moves a
// vertical swipe also runs a repeated-subtraction loop before the hand-off, and
// that loop produces its k wheel steps at one step per cycle. The
// carried remainder is below one step, so k is at most (2^COORD_BITS + 6)/8,
// which is 64 at COORD_BITS = 9 with 8-pixel steps.
// The next item is taken while a finished result still waits in the output
// register. Configuration is written through cfg_we/cfg_index/cfg_data. The user
// must write it only while the block is idle; the block does not enforce this.
module touch_swipe_wheel_and_tap_toggle_unit
	import tswt_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF,
	localparam int InW = ((2 * COORD_BITS + 34 + 7) / 8) * 8
)
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// pressed, x_pos, y_pos, now_ms, connected, zero fill
	input  logic [InW-1:0]        s_axis_tdata,
	// mode
	input  logic                  s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// wheel_delta, controls_visible, toggled, wheel_left, zero fill
	output logic [OUT_W-1:0]      m_axis_tdata,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	tswt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd),
		.sts       (sts)
	);

	tswt_dp #(
		.COORD_BITS (COORD_BITS),
		.IN_W       (InW)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (s_axis_tdata),
		.in_mode   (s_axis_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_data  (m_axis_tdata)
	);

endmodule

// File: src/tswt_ctrl.sv
module tswt_ctrl
	import tswt_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output dp_cmd_t cmd,
	input  dp_sts_t sts
);

	state_t state_q, state_n;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_n = ST_EVAL;
			ST_EVAL: state_n = sts.need_div ? ST_DIV : ST_FIN;
			ST_DIV:  if (sts.div_done) state_n = ST_FIN;
			ST_FIN:  if (out_free) state_n = ST_IDLE;
			default: state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.capture  = (state_q == ST_IDLE) && in_valid;
		cmd.eval     = (state_q == ST_EVAL);
		cmd.div_step = (state_q == ST_DIV);
		cmd.load_out = (state_q == ST_FIN) && out_free;
		in_ready     = (state_q == ST_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// File: src/tswt_dp.sv
module tswt_dp
	import tswt_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int IN_W       = 56
)
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [IN_W-1:0]       in_data,
	input  logic                  in_mode,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  dp_cmd_t               cmd,
	output dp_sts_t               sts,
	output logic [OUT_W-1:0]      out_data
);

	localparam int CW = COORD_BITS;
	localparam int RW = COORD_BITS + 2;
	localparam int BW = (COORD_BITS > 9) ? COORD_BITS : 9;
	localparam int X_LO = 1;
	localparam int Y_LO = X_LO + CW;
	localparam int T_LO = Y_LO + CW;
	localparam int C_BIT = T_LO + 32;

	// configuration
	logic [7:0]  lock_distance_q, pixels_per_step_q, tap_max_move_q;
	logic [8:0]  button_boundary_q;
	logic [15:0] tap_max_ms_q, multitap_ms_q;
	logic [6:0]  max_steps_q;

	// captured item
	logic          mode_q, pressed_q, connected_q;
	logic [CW-1:0] x_q, y_q;
	logic [31:0]   now_q;

	// block state
	logic                 tap_touching_q, tap_moved_q, visible_q;
	logic [CW-1:0]        tap_start_x_q, tap_start_y_q;
	logic [31:0]          tap_start_time_q, last_tap_time_q;
	logic [1:0]           tap_count_q;
	logic                 swipe_active_q, swipe_locked_q, swipe_rejected_q;
	logic [CW-1:0]        swipe_start_x_q, swipe_start_y_q, swipe_last_y_q;
	logic signed [RW-1:0] step_rem_q;
	logic signed [7:0]    pending_q;

	logic                 tap_touching_n, tap_moved_n, visible_n;
	logic [CW-1:0]        tap_start_x_n, tap_start_y_n;
	logic [31:0]          tap_start_time_n, last_tap_time_n;
	logic [1:0]           tap_count_n;
	logic                 swipe_active_n, swipe_locked_n, swipe_rejected_n;
	logic [CW-1:0]        swipe_start_x_n, swipe_start_y_n, swipe_last_y_n;
	logic signed [RW-1:0] step_rem_n;
	logic signed [7:0]    pending_n;

	// divider and result
	logic [RW-1:0]     div_mag_q;
	logic              div_neg_q;
	logic signed [7:0] delta_q, delta_n;
	logic              toggled_q, toggle;
	logic [OUT_W-1:0]  out_data_q;

	logic                 need_div;
	logic signed [RW-1:0] rem_pre;
	logic [31:0]          dt_start, dt_last;
	logic                 tap_in_time, gap_ok, moved_now, far, rej_start;
	logic [1:0]           cnt_inc;
	logic [CW-1:0]        tap_ax, tap_ay, sw_ax, sw_ay, sw_max;
	logic signed [CW:0]   sw_dy, y_step;
	logic signed [7:0]    lim;
	logic [7:0]           pps_eff;
	logic                 div_done;

	assign dt_start    = now_q - tap_start_time_q;
	assign dt_last     = now_q - last_tap_time_q;
	assign tap_in_time = dt_start <= {16'd0, tap_max_ms_q};
	assign gap_ok      = dt_last <= {16'd0, multitap_ms_q};
	assign cnt_inc     = (tap_count_q == 2'd0 || gap_ok) ? tap_count_q + 2'd1 : 2'd1;

	assign tap_ax = (x_q >= tap_start_x_q) ? x_q - tap_start_x_q : tap_start_x_q - x_q;
	assign tap_ay = (y_q >= tap_start_y_q) ? y_q - tap_start_y_q : tap_start_y_q - y_q;
	assign moved_now = (tap_ax > CW'(tap_max_move_q)) || (tap_ay > CW'(tap_max_move_q));

	assign sw_ax  = (x_q >= swipe_start_x_q) ? x_q - swipe_start_x_q : swipe_start_x_q - x_q;
	assign sw_ay  = (y_q >= swipe_start_y_q) ? y_q - swipe_start_y_q : swipe_start_y_q - y_q;
	assign sw_max = (sw_ax > sw_ay) ? sw_ax : sw_ay;
	assign far    = sw_max >= CW'(lock_distance_q);
	assign sw_dy  = $signed({1'b0, y_q}) - $signed({1'b0, swipe_start_y_q});
	assign y_step = $signed({1'b0, y_q}) - $signed({1'b0, swipe_last_y_q});
	assign rej_start = visible_q && (BW'(y_q) >= BW'(button_boundary_q));

	assign lim     = $signed({1'b0, max_steps_q});
	assign pps_eff = (pixels_per_step_q < MIN_STEP_PIXELS) ? MIN_STEP_PIXELS
	                                                       : pixels_per_step_q;
	assign div_done = div_mag_q < RW'(pps_eff);

	always_comb begin
		tap_touching_n   = tap_touching_q;
		tap_moved_n      = tap_moved_q;
		tap_start_x_n    = tap_start_x_q;
		tap_start_y_n    = tap_start_y_q;
		tap_start_time_n = tap_start_time_q;
		last_tap_time_n  = last_tap_time_q;
		tap_count_n      = tap_count_q;
		visible_n        = visible_q;
		swipe_active_n   = swipe_active_q;
		swipe_locked_n   = swipe_locked_q;
		swipe_rejected_n = swipe_rejected_q;
		swipe_start_x_n  = swipe_start_x_q;
		swipe_start_y_n  = swipe_start_y_q;
		swipe_last_y_n   = swipe_last_y_q;
		step_rem_n       = step_rem_q;
		pending_n        = pending_q;
		delta_n          = '0;
		toggle           = 1'b0;
		need_div         = 1'b0;
		rem_pre          = '0;

		if (mode_q) begin
			// consume: clamp pending to the per-consume limit
			if (pending_q > lim) begin
				delta_n = lim;
			end else if (pending_q < -lim) begin
				delta_n = -lim;
			end else begin
				delta_n = pending_q;
			end
			pending_n = pending_q - delta_n;
		end else begin
			// tap detector
			if (!pressed_q) begin
				if (tap_touching_q) begin
					tap_touching_n = 1'b0;
					if (!tap_moved_q && tap_in_time) begin
						last_tap_time_n = now_q;
						if (cnt_inc == TAPS_TO_TOGGLE) begin
							tap_count_n      = 2'd0;
							visible_n        = !visible_q;
							toggle           = 1'b1;
							swipe_active_n   = 1'b0;
							swipe_locked_n   = 1'b0;
							swipe_rejected_n = 1'b0;
							step_rem_n       = '0;
						end else begin
							tap_count_n = cnt_inc;
						end
					end else begin
						tap_count_n = 2'd0;
					end
				end else if (tap_count_q != 2'd0 && !gap_ok) begin
					tap_count_n = 2'd0;
				end
			end else if (!tap_touching_q) begin
				tap_touching_n   = 1'b1;
				tap_moved_n      = 1'b0;
				tap_start_x_n    = x_q;
				tap_start_y_n    = y_q;
				tap_start_time_n = now_q;
			end else if (moved_now) begin
				tap_moved_n = 1'b1;
				tap_count_n = 2'd0;
			end

			// swipe tracker, skipped on a toggle
			if (!toggle) begin
				if (!connected_q || !pressed_q) begin
					swipe_active_n   = 1'b0;
					swipe_locked_n   = 1'b0;
					swipe_rejected_n = 1'b0;
					step_rem_n       = '0;
				end else if (!swipe_active_q) begin
					swipe_active_n   = 1'b1;
					swipe_start_x_n  = x_q;
					swipe_start_y_n  = y_q;
					swipe_last_y_n   = y_q;
					swipe_rejected_n = rej_start;
					swipe_locked_n   = 1'b0;
					step_rem_n       = '0;
				end else if (swipe_rejected_q) begin
					swipe_last_y_n = y_q;
				end else if (!swipe_locked_q) begin
					if (!far) begin
						swipe_last_y_n = y_q;
					end else if (sw_ay <= sw_ax) begin
						// horizontal: last y stays where it was
						swipe_rejected_n = 1'b1;
					end else begin
						swipe_locked_n = 1'b1;
						swipe_last_y_n = y_q;
						rem_pre        = {sw_dy[CW], sw_dy};
						need_div       = 1'b1;
					end
				end else begin
					swipe_last_y_n = y_q;
					rem_pre        = step_rem_q + {y_step[CW], y_step};
					need_div       = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lock_distance_q   <= LOCK_DISTANCE_RST;
			pixels_per_step_q <= PIXELS_PER_STEP_RST;
			button_boundary_q <= BUTTON_BOUNDARY_RST;
			tap_max_ms_q      <= TAP_MAX_MS_RST;
			multitap_ms_q     <= MULTITAP_MS_RST;
			tap_max_move_q    <= TAP_MAX_MOVE_RST;
			max_steps_q       <= MAX_STEPS_RST;
			tap_touching_q    <= 1'b0;
			tap_moved_q       <= 1'b0;
			tap_start_x_q     <= '0;
			tap_start_y_q     <= '0;
			tap_start_time_q  <= '0;
			last_tap_time_q   <= '0;
			tap_count_q       <= '0;
			visible_q         <= 1'b0;
			swipe_active_q    <= 1'b0;
			swipe_locked_q    <= 1'b0;
			swipe_rejected_q  <= 1'b0;
			swipe_start_x_q   <= '0;
			swipe_start_y_q   <= '0;
			swipe_last_y_q    <= '0;
			step_rem_q        <= '0;
			pending_q         <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_LOCK_DISTANCE:   lock_distance_q   <= cfg_data[7:0];
					CFG_PIXELS_PER_STEP: pixels_per_step_q <= cfg_data[7:0];
					CFG_BUTTON_BOUNDARY: button_boundary_q <= cfg_data[8:0];
					CFG_TAP_MAX_MS:      tap_max_ms_q      <= cfg_data[15:0];
					CFG_MULTITAP_MS:     multitap_ms_q     <= cfg_data[15:0];
					CFG_TAP_MAX_MOVE:    tap_max_move_q    <= cfg_data[7:0];
					CFG_MAX_STEPS:       max_steps_q       <= cfg_data[6:0];
					default: ;
				endcase
			end
			if (cmd.eval) begin
				tap_touching_q   <= tap_touching_n;
				tap_moved_q      <= tap_moved_n;
				tap_start_x_q    <= tap_start_x_n;
				tap_start_y_q    <= tap_start_y_n;
				tap_start_time_q <= tap_start_time_n;
				last_tap_time_q  <= last_tap_time_n;
				tap_count_q      <= tap_count_n;
				visible_q        <= visible_n;
				swipe_active_q   <= swipe_active_n;
				swipe_locked_q   <= swipe_locked_n;
				swipe_rejected_q <= swipe_rejected_n;
				swipe_start_x_q  <= swipe_start_x_n;
				swipe_start_y_q  <= swipe_start_y_n;
				swipe_last_y_q   <= swipe_last_y_n;
				step_rem_q       <= step_rem_n;
				pending_q        <= pending_n;
			end
			if (cmd.div_step) begin
				if (!div_done) begin
					// one wheel step per cycle; same-sign steps make saturating
					// each one equal to saturating the total
					if (div_neg_q) begin
						if (pending_q != PENDING_MIN) pending_q <= pending_q - 8'sd1;
					end else begin
						if (pending_q != PENDING_MAX) pending_q <= pending_q + 8'sd1;
					end
				end else begin
					step_rem_q <= div_neg_q ? -$signed(div_mag_q) : $signed(div_mag_q);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q      <= in_mode;
			pressed_q   <= in_data[0];
			x_q         <= in_data[X_LO +: CW];
			y_q         <= in_data[Y_LO +: CW];
			now_q       <= in_data[T_LO +: 32];
			connected_q <= in_data[C_BIT];
		end
		if (cmd.eval) begin
			div_neg_q <= rem_pre[RW-1];
			div_mag_q <= rem_pre[RW-1] ? $unsigned(-rem_pre) : $unsigned(rem_pre);
			delta_q   <= delta_n;
			toggled_q <= toggle;
		end
		if (cmd.div_step && !div_done) begin
			div_mag_q <= div_mag_q - RW'(pps_eff);
		end
		if (cmd.load_out) begin
			out_data_q <= {6'd0, pending_q, toggled_q, visible_q, delta_q};
		end
	end

	assign sts.need_div = need_div;
	assign sts.div_done = div_done;
	assign out_data     = out_data_q;

endmodule

// File: src/tswt_chk.sv
module tswt_chk
	import tswt_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             s_axis_tvalid,
	input logic             s_axis_tready,
	input logic             m_axis_tvalid,
	input logic             m_axis_tready,
	input logic [OUT_W-1:0] m_axis_tdata
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output changed while stalled");

	// every item passes through evaluation before the next one is taken
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted on back-to-back cycles");

	// a toggle comes from a touch sample, which never hands out wheel steps
	a_toggle_no_delta: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[9] |-> m_axis_tdata[7:0] == 8'd0)
		else $error("toggle with nonzero wheel delta");

	// pending is saturated symmetrically
	a_pending_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[17:10] != 8'h80)
		else $error("pending steps out of range");

	// a positive consume never leaves negative pending
	a_consume_sign: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[7] && m_axis_tdata[7:0] != 8'd0
		|-> !m_axis_tdata[17])
		else $error("consume flipped the sign of pending steps");

endmodule

bind touch_swipe_wheel_and_tap_toggle_unit tswt_chk u_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
